[rtl/bcps_pkg.sv]
// Shared types and constants for the baseline crossing polygon splitter.
package bcps_pkg;

    // Default coordinate width of points, vertices and the baseline
    localparam int COORD_BITS_DEF = 16;

    // Top-level sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_FIX,
        ST_ADJ,
        ST_EMIT
    } bcps_state_t;

    // What an accepted point does to the polygon stream
    typedef enum logic [1:0] {
        KIND_FIRST,
        KIND_PASS,
        KIND_CROSS
    } bcps_kind_t;

    // Phases of the shared multiply/divide unit
    typedef enum logic [1:0] {
        MD_IDLE,
        MD_SUM,
        MD_MUL,
        MD_DIV
    } bcps_md_phase_t;

    // Status from the multiply/divide unit to the sequencer
    typedef struct packed {
        logic done;
        logic rem_nz;
    } bcps_md_stat_t;

endpackage

[rtl/bcps_alu.sv]
// Shared adder/subtractor with carry out, reused for every arithmetic step of the multiply/divide unit.
module bcps_alu
    import bcps_pkg::*;
#(
    parameter int WIDTH = COORD_BITS_DEF + 2
)
(
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    input  logic             sub,
    output logic [WIDTH:0]   res    // {carry, sum}; on sub, carry set means a >= b
);

    logic [WIDTH-1:0] b_op;

    // Invert the second operand and add one to subtract
    assign b_op = sub ? ~b : b;
    assign res  = {1'b0, a} + {1'b0, b_op} + {{WIDTH{1'b0}}, sub};

endmodule

[rtl/bcps_muldiv.sv]
// Iterative unit: s = r1 + r2, m = r1 * adx by shift-add, then q = m / s by restoring division.
module bcps_muldiv
    import bcps_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [COORD_BITS-1:0] r1,
    input  logic [COORD_BITS-1:0] r2,
    input  logic [COORD_BITS-1:0] adx,
    output logic [COORD_BITS-1:0] quot,
    output bcps_md_stat_t         stat
);

    localparam int N     = COORD_BITS;
    localparam int AW    = N + 2;
    localparam int CNT_W = $clog2(N);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(N - 1);

    bcps_md_phase_t phase_reg, phase_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [N-1:0]     r1_reg;
    logic [N:0]       s_reg;
    logic [N:0]       hi_reg;   // partial product high half, then remainder
    logic [N-1:0]     lo_reg;   // multiplier bits, product low half, then quotient

    logic [AW-1:0] alu_a, alu_b;
    logic          alu_sub;
    logic [AW:0]   alu_res;

    bcps_alu #(.WIDTH(AW)) u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .sub (alu_sub),
        .res (alu_res)
    );

    // Sequence the phases
    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        case (phase_reg)
            MD_IDLE:
            begin
                if (start)
                begin
                    phase_next = MD_SUM;
                end
            end
            MD_SUM:
            begin
                phase_next = MD_MUL;
                cnt_next   = CNT_LAST;
            end
            MD_MUL:
            begin
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    phase_next = MD_DIV;
                    cnt_next   = CNT_LAST;
                end
            end
            MD_DIV:
            begin
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    phase_next = MD_IDLE;
                    done_next  = 1'b1;
                end
            end
            default:
            begin
                phase_next = MD_IDLE;
            end
        endcase
    end

    // Select the operands of the shared unit
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (phase_reg)
            MD_SUM:
            begin
                alu_a = {2'b00, r1_reg};
                alu_b = {1'b0, hi_reg};
            end
            MD_MUL:
            begin
                alu_a = {1'b0, hi_reg};
                alu_b = lo_reg[0] ? {2'b00, r1_reg} : '0;
            end
            MD_DIV:
            begin
                alu_a   = {hi_reg, lo_reg[N-1]};
                alu_b   = {1'b0, s_reg};
                alu_sub = 1'b1;
            end
            default:
            begin
                alu_sub = 1'b0;
            end
        endcase
    end

    // Advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= MD_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    // Advance the working registers one step
    always_ff @(posedge clk)
    begin
        case (phase_reg)
            MD_IDLE:
            begin
                if (start)
                begin
                    r1_reg <= r1;
                    hi_reg <= {1'b0, r2};
                    lo_reg <= adx;
                end
            end
            MD_SUM:
            begin
                s_reg  <= alu_res[N:0];
                hi_reg <= '0;
            end
            MD_MUL:
            begin
                hi_reg <= {1'b0, alu_res[N:1]};
                lo_reg <= {alu_res[0], lo_reg[N-1:1]};
            end
            MD_DIV:
            begin
                hi_reg <= alu_res[AW] ? alu_res[N:0] : alu_a[N:0];
                lo_reg <= {lo_reg[N-2:0], alu_res[AW]};
            end
            default:
            begin
                hi_reg <= hi_reg;
            end
        endcase
    end

    assign quot        = lo_reg;
    assign stat.done   = done_reg;
    assign stat.rem_nz = |hi_reg;

endmodule

[rtl/baseline_crossing_polygon_splitter_core.sv]
// Top level: point intake, crossing sequencer and vertex output of the polygon splitter.
//
// Usage:
//   Points enter on the s_ channel (s_tuser = first_point, s_tdata = {point_y, point_x}).
//   Polygon vertices leave on the m_ channel (m_tdata = {out_y, out_x},
//   m_tuser = {closed_above, closes_polygon}, m_tlast = last vertex of that point).
//   base_level is written through cfg_we / cfg_wdata while no point is in work.
// Timing:
//   One point is in work at a time; s_tready is low from the transfer of a point
//   until its last vertex has been taken.
//   A pass-through point and a curve start go straight to output; a baseline
//   crossing is first worked out by the shared adder: r1 + r2, then the
//   shift-add product, then the restoring divide for the crossing column.
// Reset:
//   Clears base_level to zero and forgets the previous point, so the next point
//   starts a curve.
// Stall:
//   m_tvalid and the vertex hold until m_tready; no new point is taken meanwhile.
module baseline_crossing_polygon_splitter_core
    import bcps_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [COORD_BITS-1:0]                 cfg_wdata,   // base_level
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]     s_tdata,     // point_x, point_y, zero pad
    input  logic                                  s_tuser,     // first_point
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [((2*COORD_BITS+7)/8)*8-1:0]     m_tdata,     // out_x, out_y, zero pad
    output logic [1:0]                            m_tuser,     // closes_polygon, closed_above
    output logic                                  m_tlast      // last_of_item
);

    localparam int N    = COORD_BITS;
    localparam int DW   = ((2 * N + 7) / 8) * 8;
    localparam logic signed [N-1:0] X_MAX = {1'b0, {(N-1){1'b1}}};

    bcps_state_t state_reg, state_next;
    bcps_kind_t  kind_reg, in_kind;

    logic signed [N-1:0] base_reg;
    logic                have_point_reg;
    logic signed [N-1:0] px_reg, py_reg, x0_reg;
    logic signed [N-1:0] c_reg;
    logic signed [N+1:0] w_reg;
    logic                above_reg, dxneg_reg;
    logic [1:0]          emit_idx_reg;

    logic signed [N-1:0] in_x, in_y;
    logic                in_take, new_curve, same_side, in_above;
    logic signed [N:0]   dy1, dy2, dxd;
    logic [N-1:0]        r1, r2, adx;
    logic                md_start;
    logic [N-1:0]        quot;
    bcps_md_stat_t       md_stat;
    logic signed [N+1:0] fl, w_next, w_adj;
    logic signed [N-1:0] cp1;
    logic                out_take, emit_last;
    logic signed [N-1:0] out_x, out_y;
    logic                closes_polygon, closed_above;

    assign in_x = $signed(s_tdata[N-1:0]);
    assign in_y = $signed(s_tdata[2*N-1:N]);

    // Classify the incoming point against the previous one
    assign new_curve = s_tuser || !have_point_reg;
    assign same_side = ((in_y > base_reg) && (py_reg > base_reg)) ||
                       ((in_y < base_reg) && (py_reg < base_reg)) ||
                       ((in_y == base_reg) && (py_reg == base_reg));
    assign in_above  = !((py_reg <= base_reg) && (in_y >= base_reg));

    always_comb
    begin
        if (new_curve)
        begin
            in_kind = KIND_FIRST;
        end
        else if (same_side)
        begin
            in_kind = KIND_PASS;
        end
        else
        begin
            in_kind = KIND_CROSS;
        end
    end

    // Distances to the baseline and column step
    assign dy1 = {py_reg[N-1], py_reg} - {base_reg[N-1], base_reg};
    assign dy2 = {in_y[N-1], in_y} - {base_reg[N-1], base_reg};
    assign dxd = {in_x[N-1], in_x} - {px_reg[N-1], px_reg};
    assign r1  = dy1[N] ? N'(-dy1) : dy1[N-1:0];
    assign r2  = dy2[N] ? N'(-dy2) : dy2[N-1:0];
    assign adx = dxd[N] ? N'(-dxd) : dxd[N-1:0];

    bcps_muldiv #(.COORD_BITS(N)) u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (md_start),
        .r1    (r1),
        .r2    (r2),
        .adx   (adx),
        .quot  (quot),
        .stat  (md_stat)
    );

    // Signed offset from the floored quotient, then truncate toward zero
    always_comb
    begin
        if (!dxneg_reg)
        begin
            fl = {2'b00, quot};
        end
        else if (md_stat.rem_nz)
        begin
            fl = ~{2'b00, quot};
        end
        else
        begin
            fl = -{2'b00, quot};
        end
    end
    assign w_next = {{2{x0_reg[N-1]}}, x0_reg} + fl;
    assign w_adj  = w_reg + {{(N+1){1'b0}}, (md_stat.rem_nz && w_reg[N+1])};
    assign cp1    = (c_reg == X_MAX) ? c_reg : c_reg + 1'b1;

    // Next-state logic
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = (in_kind == KIND_CROSS) ? ST_CALC : ST_EMIT;
                end
            end
            ST_CALC:
            begin
                if (md_stat.done)
                begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX:
            begin
                state_next = ST_ADJ;
            end
            ST_ADJ:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (m_tready && emit_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Handshake and unit control outputs
    always_comb
    begin
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        md_start = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                md_start = s_tvalid && (in_kind == KIND_CROSS);
            end
            ST_EMIT:
            begin
                m_tvalid = 1'b1;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign in_take  = s_tvalid && s_tready;
    assign out_take = m_tvalid && m_tready;

    // Select the vertex for the current output slot
    always_comb
    begin
        out_x          = px_reg;
        out_y          = py_reg;
        closes_polygon = 1'b0;
        closed_above   = 1'b0;
        emit_last      = 1'b1;
        case (kind_reg)
            KIND_FIRST:
            begin
                if (emit_idx_reg == 2'd0)
                begin
                    out_y     = base_reg;
                    emit_last = 1'b0;
                end
            end
            KIND_CROSS:
            begin
                if (emit_idx_reg == 2'd0)
                begin
                    out_x          = c_reg;
                    out_y          = base_reg;
                    closes_polygon = 1'b1;
                    closed_above   = above_reg;
                    emit_last      = 1'b0;
                end
                else if (emit_idx_reg == 2'd1)
                begin
                    out_x     = cp1;
                    out_y     = base_reg;
                    emit_last = 1'b0;
                end
            end
            default:
            begin
                emit_last = 1'b1;
            end
        endcase
    end

    assign m_tdata = DW'({out_y, out_x});
    assign m_tuser = {closed_above, closes_polygon};
    assign m_tlast = emit_last;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            base_reg       <= '0;
            have_point_reg <= 1'b0;
            emit_idx_reg   <= '0;
            kind_reg       <= KIND_FIRST;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                base_reg <= $signed(cfg_wdata);
            end
            if (in_take)
            begin
                have_point_reg <= 1'b1;
                kind_reg       <= in_kind;
                emit_idx_reg   <= '0;
            end
            else if (out_take)
            begin
                emit_idx_reg <= emit_idx_reg + 1'b1;
            end
        end
    end

    // Point and crossing payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            px_reg    <= in_x;
            py_reg    <= in_y;
            x0_reg    <= px_reg;
            above_reg <= in_above;
            dxneg_reg <= dxd[N];
        end
        if (state_reg == ST_FIX)
        begin
            w_reg <= w_next;
        end
        if (state_reg == ST_ADJ)
        begin
            c_reg <= w_adj[N-1:0];
        end
    end

endmodule

[rtl/bcps_checker.sv]
// Port-level checks for the polygon splitter, bound to the top level.
module bcps_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic       m_tlast,
    input logic [1:0] m_tuser
);

    // One point in work at a time: never take a point while a vertex is offered
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready while a vertex is offered");

    // Drop ready after a point transfer
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("ready stayed high after a point transfer");

    // Return to ready once the last vertex of a point is taken
    a_ready_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("not ready after the last vertex of a point");

    // Side flag appears only on a closing vertex
    a_above_on_close: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> m_tuser[0])
        else $error("closed_above set on a vertex that does not close");

    // A closing vertex is never the last vertex of its point
    a_close_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> !m_tlast)
        else $error("closing vertex marked as last of its point");

endmodule

bind baseline_crossing_polygon_splitter_core bcps_checker u_bcps_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
